[rtl/core/wzcd_pkg.sv]
// ----------------------------------------------------------------------------
// wzcd_pkg
// shared types, codes, defaults and helpers of the windowed z-score detector
// ----------------------------------------------------------------------------
package wzcd_pkg;

  // default build values
  localparam int WZCD_WINDOW_DEPTH = 2048;
  localparam int WZCD_SAMPLE_BITS  = 16;

  // configuration register indexes
  localparam logic [1:0] REG_WINDOW_COUNT  = 2'd0;
  localparam logic [1:0] REG_ABS_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_SIGMA_GAIN    = 2'd2;

  // register reset values
  localparam logic [11:0] WINDOW_COUNT_RESET  = 12'd16;
  localparam logic [15:0] ABS_THRESHOLD_RESET = 16'd0;
  localparam logic [15:0] SIGMA_GAIN_RESET    = 16'd768;

  // change codes
  localparam logic [1:0] CHG_NONE = 2'd0;
  localparam logic [1:0] CHG_UP   = 2'd1;
  localparam logic [1:0] CHG_DOWN = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL1,
    ST_MUL2,
    ST_DIFF,
    ST_START,
    ST_DIV,
    ST_ROOT,
    ST_OUT
  } wzcd_state_t;

  // window length in use: zero reads as one, clipped to the store depth
  function automatic int unsigned eff_count(logic [11:0] wc, int unsigned depth);
    int unsigned c;
    c = 32'(wc);
    if (c == 0) begin
      c = 1;
    end else if (c > depth) begin
      c = depth;
    end
    return c;
  endfunction

endpackage

[rtl/core/wzcd_window_mem.sv]
// ----------------------------------------------------------------------------
// wzcd_window_mem
// sample window store, one write and one registered read port
// ----------------------------------------------------------------------------
module wzcd_window_mem #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/wzcd_divider.sv]
// ----------------------------------------------------------------------------
// wzcd_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wzcd_divider #(
  parameter int QW = 48,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] rem_init,     // upper dividend part, below divisor
  input  logic [QW-1:0] dividend_lo,
  input  logic [DW-1:0] divisor,
  output logic [QW-1:0] quotient,
  output logic          done
);

  localparam int CW = (QW > 1) ? $clog2(QW) : 1;

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [QW-1:0] dq;
  logic [DW:0]   trial;
  logic          ge;

  always_comb begin
    trial = {rem, dq[QW-1]};
    ge    = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem_init;
      dq  <= dividend_lo;
    end else if (busy) begin
      rem <= ge ? DW'(trial - {1'b0, divisor}) : DW'(trial);
      dq  <= {dq[QW-2:0], ge};
    end
  end

  assign quotient = dq;

endmodule

[rtl/core/wzcd_isqrt.sv]
// ----------------------------------------------------------------------------
// wzcd_isqrt
// digit-by-digit integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module wzcd_isqrt #(
  parameter int OW = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2*OW-1:0] radicand,
  output logic [OW-1:0]   root,
  output logic            done
);

  localparam int CW = (OW > 1) ? $clog2(OW) : 1;

  logic            busy;
  logic [CW-1:0]   cnt;
  logic [2*OW-1:0] rad;
  logic [OW+1:0]   rem;
  logic [OW+3:0]   r4;
  logic [OW+3:0]   trial;
  logic            ge;

  always_comb begin
    r4    = {rem, rad[2*OW-1:2*OW-2]};
    trial = {2'b00, root, 2'b01};
    ge    = r4 >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(OW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= ge ? (OW+2)'(r4 - trial) : (OW+2)'(r4);
      root <= {root[OW-2:0], ge};
    end
  end

endmodule

[rtl/core/window_zscore_change_detector.sv]
// ----------------------------------------------------------------------------
// window_zscore_change_detector
// moving-window mean / standard deviation with z-score style change flags
// ----------------------------------------------------------------------------
// one sample transaction in, one result transaction out. the last window_count
// samples sit in a single-port-write, registered-read memory; the running sum
// and sum of squares are read-modify-written around it. an item goes through
// acceptance, read, multiply, unit handover, the variance division (scaled by
// 2^16 over n*n, one quotient bit a cycle, with the mean division running
// alongside), the square root and the output load; one sample is worked at a
// time. the divider loop is the longest step. the next sample is taken while a
// finished result still waits in the output register. no clearing pass:
// entries are only read once the write pointer has lapped the window, earlier
// reads count as zero. writing window_count restarts the detector (window,
// sums, warm-up).
// ----------------------------------------------------------------------------
module window_zscore_change_detector
  import wzcd_pkg::*;
#(
  parameter int WINDOW_DEPTH = WZCD_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = WZCD_SAMPLE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // sample channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] sample,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  change,
  output logic [23:0] mean_q8,
  output logic [23:0] std_dev_q8,
  output logic        armed,
  output logic [15:0] last_sample
);

  localparam int SB    = SAMPLE_BITS;
  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = SB + CNT_W;          // running sum
  localparam int SQ_W  = 2 * SB + CNT_W;      // running sum of squares
  localparam int V_W   = 2 * SB + 2 * CNT_W;  // n*sumsq - sum^2
  localparam int N2_W  = 2 * CNT_W;
  localparam int H     = (SQ_W + 1) / 2;      // split of the n*sumsq product
  localparam int QW    = 2 * SB + 16;         // variance quotient, q16 scaled
  localparam int MQ    = SB + 8;              // mean quotient, q8
  localparam int RW    = QW / 2;              // root width

  // configuration registers
  logic [11:0] window_count;
  logic [15:0] abs_threshold;
  logic [15:0] sigma_gain;
  logic [CNT_W-1:0] count_eff;

  // detector state
  wzcd_state_t state, state_next;
  logic [AW-1:0]    ptr;
  logic [AW-1:0]    ptr_next;
  logic [AW:0]      ptr_inc;
  logic             wrapped;          // pointer has lapped the window
  logic [SUM_W-1:0] sum;
  logic [SQ_W-1:0]  sumsq;
  logic [CNT_W-1:0] warmup;
  logic             primed;
  logic [23:0]      mean_reg;
  logic [23:0]      sigma_reg;

  // per-item working registers
  logic [SB-1:0]         s_reg;
  logic                  was_armed;
  logic [1:0]            chg;
  logic [V_W-1:0]        sq_prod;
  logic [CNT_W+H-1:0]    nsq_lo;
  logic [V_W-H-1:0]      nsq_hi;
  logic [N2_W-1:0]       n2;
  logic [V_W-1:0]        v_reg;
  logic [39:0]           lim_b;

  // datapath terms
  logic [SB-1:0]   rd_data;
  logic [SB-1:0]   old;
  logic [2*SB-1:0] old_sq;
  logic [2*SB-1:0] new_sq;
  logic [23:0]     s_q8;
  logic [23:0]     diff;
  logic [39:0]     lim;
  logic [39:0]     lim_a;
  logic            flag;
  logic [V_W-1:0]  nsq;

  // control strobes
  logic mem_re, mem_we, div_start, sqrt_start, out_load;

  // unit results
  logic [QW-1:0] var_q;
  logic          var_done;
  logic [MQ-1:0] mean_q;
  logic          mean_done;
  logic [RW-1:0] root;
  logic          root_done;

  assign count_eff = CNT_W'(eff_count(window_count, WINDOW_DEPTH));

  // circular pointer steps through 0 .. count-1
  always_comb begin
    ptr_inc = {1'b0, ptr} + 1'b1;
    if (32'(ptr_inc) == 32'(count_eff)) begin
      ptr_next = '0;
    end else begin
      ptr_next = ptr_inc[AW-1:0];
    end
  end

  // configuration registers, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      window_count  <= WINDOW_COUNT_RESET;
      abs_threshold <= ABS_THRESHOLD_RESET;
      sigma_gain    <= SIGMA_GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WINDOW_COUNT:  window_count  <= cfg_data[11:0];
        REG_ABS_THRESHOLD: abs_threshold <= cfg_data;
        REG_SIGMA_GAIN:    sigma_gain    <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_READ;
      ST_READ:  state_next = ST_MUL1;
      ST_MUL1:  state_next = ST_MUL2;
      ST_MUL2:  state_next = ST_DIFF;
      ST_DIFF:  state_next = ST_START;
      ST_START: state_next = ST_DIV;
      ST_DIV:   if (var_done) state_next = ST_ROOT;
      ST_ROOT:  if (root_done) state_next = ST_OUT;
      ST_OUT:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready   = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        mem_re   = in_valid;
      end
      ST_READ:  mem_we = 1'b1;
      ST_START: div_start = 1'b1;
      ST_DIV:   sqrt_start = var_done;
      ST_OUT:   out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  // read-modify-write of the window entry and the detection test
  always_comb begin
    old    = wrapped ? rd_data : '0;
    old_sq = old * old;
    new_sq = s_reg * s_reg;
    s_q8   = 24'({s_reg, 8'b0});
    diff   = (s_q8 > mean_reg) ? (s_q8 - mean_reg) : (mean_reg - s_q8);
    lim_a  = {8'b0, abs_threshold, 16'b0};
    lim    = (lim_a > lim_b) ? lim_a : lim_b;
    flag   = {8'b0, diff, 8'b0} > lim;
    nsq    = (V_W'(nsq_hi) << H) + V_W'(nsq_lo);
  end

  // control and running state, restart on a window_count write
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ptr       <= '0;
      wrapped   <= 1'b0;
      sum       <= '0;
      sumsq     <= '0;
      warmup    <= CNT_W'(eff_count(WINDOW_COUNT_RESET, WINDOW_DEPTH));
      primed    <= 1'b0;
      mean_reg  <= '0;
      sigma_reg <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write && cfg_index == REG_WINDOW_COUNT) begin
        ptr       <= '0;
        wrapped   <= 1'b0;
        sum       <= '0;
        sumsq     <= '0;
        warmup    <= CNT_W'(eff_count(cfg_data[11:0], WINDOW_DEPTH));
        primed    <= 1'b0;
        mean_reg  <= '0;
        sigma_reg <= '0;
      end else begin
        // warm-up count runs on each accepted transaction
        if (in_valid && in_ready) begin
          ptr <= ptr_next;
          if (!primed) begin
            if (warmup <= CNT_W'(1)) begin
              warmup <= '0;
              primed <= 1'b1;
            end else begin
              warmup <= warmup - 1'b1;
            end
          end
        end
        if (state == ST_READ) begin
          sum     <= sum - SUM_W'(old) + SUM_W'(s_reg);
          sumsq   <= sumsq - SQ_W'(old_sq) + SQ_W'(new_sq);
          wrapped <= wrapped || (ptr == '0);
        end
        if (state == ST_ROOT && root_done) begin
          mean_reg  <= 24'(mean_q);
          sigma_reg <= 24'(root);
        end
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    lim_b <= 40'(sigma_gain) * 40'(sigma_reg);
    if (in_valid && in_ready) begin
      s_reg     <= sample[SB-1:0];
      was_armed <= primed;
    end
    if (state == ST_READ) begin
      if (was_armed && flag) begin
        chg <= (s_q8 > mean_reg) ? CHG_UP : CHG_DOWN;
      end else begin
        chg <= CHG_NONE;
      end
    end
    if (state == ST_MUL1) begin
      sq_prod <= V_W'(sum) * V_W'(sum);
      nsq_lo  <= (CNT_W+H)'(count_eff) * (CNT_W+H)'(sumsq[H-1:0]);
    end
    if (state == ST_MUL2) begin
      nsq_hi <= (V_W-H)'(count_eff) * (V_W-H)'(sumsq[SQ_W-1:H]);
      n2     <= N2_W'(count_eff) * N2_W'(count_eff);
    end
    if (state == ST_DIFF) begin
      v_reg <= (nsq > sq_prod) ? (nsq - sq_prod) : '0;
    end
    if (out_load) begin
      change      <= chg;
      mean_q8     <= mean_reg;
      std_dev_q8  <= sigma_reg;
      armed       <= was_armed;
      last_sample <= 16'(s_reg);
    end
  end

  wzcd_window_mem #(
    .DEPTH (WINDOW_DEPTH),
    .WIDTH (SB)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ptr),
    .wdata (s_reg),
    .re    (mem_re),
    .raddr (ptr_next),
    .rdata (rd_data)
  );

  // (n*sumsq - sum^2) * 2^16 / n^2, the variance in q16
  wzcd_divider #(
    .QW (QW),
    .DW (N2_W)
  ) u_var_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .rem_init    (v_reg[V_W-1:2*SB]),
    .dividend_lo ({v_reg[2*SB-1:0], 16'b0}),
    .divisor     (n2),
    .quotient    (var_q),
    .done        (var_done)
  );

  // sum * 2^8 / n
  wzcd_divider #(
    .QW (MQ),
    .DW (CNT_W)
  ) u_mean_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .rem_init    (sum[SUM_W-1:SB]),
    .dividend_lo ({sum[SB-1:0], 8'b0}),
    .divisor     (count_eff),
    .quotient    (mean_q),
    .done        (mean_done)
  );

  wzcd_isqrt #(
    .OW (RW)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (var_q),
    .root     (root),
    .done     (root_done)
  );

  // mean division always finishes ahead of the variance division
  logic unused_mean_done;
  assign unused_mean_done = mean_done;

endmodule

[rtl/core/wzcd_checker.sv]
// ----------------------------------------------------------------------------
// wzcd_checker
// port-level checks of the windowed z-score detector
// ----------------------------------------------------------------------------
module wzcd_checker
  import wzcd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  change,
  input logic [23:0] mean_q8,
  input logic [23:0] std_dev_q8,
  input logic        armed,
  input logic [15:0] last_sample
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mean_q8) && $stable(std_dev_q8)
      && $stable(change) && $stable(armed) && $stable(last_sample))
    else $error("result changed while stalled");

  // no flag during warm-up
  a_warmup_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !armed |-> change == CHG_NONE)
    else $error("change flagged before armed");

  a_change_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> change == CHG_NONE || change == CHG_UP || change == CHG_DOWN)
    else $error("illegal change code");

  // one sample in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

endmodule

bind window_zscore_change_detector wzcd_checker u_wzcd_checker (.*);

[verif/wzcd_scoreboard.sv]
// ----------------------------------------------------------------------------
// wzcd_scoreboard
// Watches the configuration port and both channels of the windowed z-score
// detector. It keeps its own copy of the window, the sums and the registers,
// predicts one result for every accepted sample and compares each accepted
// result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module wzcd_scoreboard
  import wzcd_pkg::*;
#(
  parameter int WINDOW_DEPTH = WZCD_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = WZCD_SAMPLE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] sample,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  change,
  input  logic [23:0] mean_q8,
  input  logic [23:0] std_dev_q8,
  input  logic        armed,
  input  logic [15:0] last_sample,
  output int          fail_count,
  output int          outstanding,
  output int          results_seen,
  output int          ups_seen,
  output int          downs_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  change;
    logic [23:0] mean_q8;
    logic [23:0] std_dev_q8;
    logic        armed;
    logic [15:0] last_sample;
  } zscore_result_t;

  zscore_result_t pending_results[$];

  // shadow of the block's registers and window
  logic [11:0]       win_count_reg;
  logic [15:0]       threshold_reg;
  logic [15:0]       gain_reg;
  logic [15:0]       window_mem [WINDOW_DEPTH];
  int unsigned       wr_ptr;
  longint unsigned   sum_acc;
  longint unsigned   sumsq_acc;
  int unsigned       warm_left;
  logic              is_primed;
  longint unsigned   mean_hold;
  longint unsigned   sigma_hold;

  function automatic int unsigned window_len();
    int unsigned c;
    c = win_count_reg;
    if (c == 0) begin
      c = 1;
    end else if (c > WINDOW_DEPTH) begin
      c = WINDOW_DEPTH;
    end
    return c;
  endfunction

  // bit-by-bit integer square root
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= root + b) begin
        x = x - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  task automatic restart_window();
    for (int i = 0; i < WINDOW_DEPTH; i++) window_mem[i] = '0;
    wr_ptr     = 0;
    sum_acc    = 0;
    sumsq_acc  = 0;
    warm_left  = window_len();
    is_primed  = 1'b0;
    mean_hold  = 0;
    sigma_hold = 0;
  endtask

  // one sample in, one result out
  function automatic zscore_result_t predict_zscore(logic [15:0] raw);
    zscore_result_t  r;
    longint unsigned n, s, s_q8, diff, lim_a, lim_b, lim, oldv, v, sq, q, rem, d;
    n    = window_len();
    s    = raw & ((64'd1 << SAMPLE_BITS) - 1);
    r    = '0;
    r.change = CHG_NONE;
    r.armed  = is_primed;
    if (is_primed) begin
      s_q8  = s << 8;
      diff  = (s_q8 > mean_hold) ? s_q8 - mean_hold : mean_hold - s_q8;
      lim_a = longint'(threshold_reg) << 16;
      lim_b = longint'(gain_reg) * sigma_hold;
      lim   = (lim_a > lim_b) ? lim_a : lim_b;
      if ((diff << 8) > lim) r.change = (s_q8 > mean_hold) ? CHG_UP : CHG_DOWN;
    end else if (warm_left <= 1) begin
      warm_left = 0;
      is_primed = 1'b1;
    end else begin
      warm_left--;
    end
    wr_ptr = (wr_ptr + 1) % n;
    oldv = window_mem[wr_ptr];
    sum_acc   = sum_acc - oldv + s;
    sumsq_acc = sumsq_acc - oldv * oldv + s * s;
    window_mem[wr_ptr] = s[15:0];
    sq  = sum_acc * sum_acc;
    v   = n * sumsq_acc;
    v   = (v > sq) ? v - sq : 0;
    q   = v / (n * n);
    rem = v % (n * n);
    d   = (q << 16) + ((rem << 16) / (n * n));
    mean_hold  = ((sum_acc << 8) / n) & 24'hFFFFFF;
    sigma_hold = int_sqrt(d) & 24'hFFFFFF;
    r.mean_q8     = mean_hold[23:0];
    r.std_dev_q8  = sigma_hold[23:0];
    r.last_sample = s[15:0];
    return r;
  endfunction

  task automatic report_field(string name, longint unsigned exp_v, longint unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: mismatch on %s, expected %0d, got %0d", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  assign outstanding = pending_results.size();

  always @(posedge clk) begin
    zscore_result_t exp_r;
    if (rst) begin
      win_count_reg = WINDOW_COUNT_RESET;
      threshold_reg = ABS_THRESHOLD_RESET;
      gain_reg      = SIGMA_GAIN_RESET;
      restart_window();
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (change == CHG_UP) ups_seen++;
        if (change == CHG_DOWN) downs_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected, got mean %0d", $time, mean_q8);
          fail_count++;
        end else begin
          exp_r = pending_results.pop_front();
          report_field("change", exp_r.change, change);
          report_field("mean_q8", exp_r.mean_q8, mean_q8);
          report_field("std_dev_q8", exp_r.std_dev_q8, std_dev_q8);
          report_field("armed", exp_r.armed, armed);
          report_field("last_sample", exp_r.last_sample, last_sample);
        end
      end
      if (in_valid && in_ready) pending_results.push_back(predict_zscore(sample));
      if (cfg_write) begin
        case (cfg_index)
          REG_WINDOW_COUNT: begin
            win_count_reg = cfg_data[11:0];
            restart_window();
          end
          REG_ABS_THRESHOLD: threshold_reg = cfg_data;
          REG_SIGMA_GAIN:    gain_reg = cfg_data;
          default: ;
        endcase
      end
    end
  end

  initial begin
    fail_count   = 0;
    results_seen = 0;
    ups_seen     = 0;
    downs_seen   = 0;
  end

endmodule

[verif/tb_window_zscore_change_detector.sv]
// ----------------------------------------------------------------------------
// tb_window_zscore_change_detector
// Drives samples and register settings into the windowed z-score detector.
// A directed opening covers warm-up, arming and the sample extremes; random
// phases then run noisy signals with spikes under many window, threshold and
// gain settings. Checking is left to the scoreboard and the bound checker.
// ----------------------------------------------------------------------------
module tb_window_zscore_change_detector;
  import wzcd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no transaction before the run is called hung
  localparam int STALL_LIMIT = 6000;
  // settle time after the results drain, with margin
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_OFF_CYCLES = 500;
  // register index with nothing behind it
  localparam logic [1:0] REG_UNUSED_INDEX = 2'd3;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] sample;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  change;
  logic [23:0] mean_q8;
  logic [23:0] std_dev_q8;
  logic        armed;
  logic [15:0] last_sample;

  int fail_count, outstanding, results_seen, ups_seen, downs_seen;
  int samples_sent;
  int idle_cycles;
  int settings_used;
  bit no_gaps;       // stretch with no idling on either side
  bit hold_request;  // asks the receiver for one long hold-off

  window_zscore_change_detector i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .sample(sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .change(change), .mean_q8(mean_q8), .std_dev_q8(std_dev_q8),
    .armed(armed), .last_sample(last_sample)
  );

  wzcd_scoreboard i_scoreboard (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .sample(sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .change(change), .mean_q8(mean_q8), .std_dev_q8(std_dev_q8),
    .armed(armed), .last_sample(last_sample),
    .fail_count(fail_count), .outstanding(outstanding),
    .results_seen(results_seen), .ups_seen(ups_seen), .downs_seen(downs_seen)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // watchdog: ends the run if no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random back-pressure, one long hold-off on request
  // while the sender is offering samples
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && in_valid) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        out_ready <= 1'b1;
      end else begin
        out_ready <= no_gaps || ($urandom_range(99) >= 12);
      end
    end
  end

  // one sample transaction, with a random gap afterwards now and then
  task automatic send_sample(logic [15:0] value);
    int gap;
    in_valid <= 1'b1;
    sample   <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
    if (!no_gaps && $urandom_range(99) < 12) begin
      gap = $urandom_range(6, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender goes quiet until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // register writes only once the block is idle
  task automatic write_settings(logic [11:0] wc, logic [15:0] thr, logic [15:0] gain);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_ABS_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    cfg_index <= REG_SIGMA_GAIN;
    cfg_data  <= gain;
    @(posedge clk);
    cfg_index <= REG_WINDOW_COUNT;
    cfg_data  <= {4'h0, wc};
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
    @(posedge clk);
  endtask

  // noisy level with spikes and the odd extreme
  function automatic logic [15:0] next_signal(int level, int spread);
    int pick, v;
    pick = $urandom_range(99);
    if (pick < 5) return ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
    if (pick < 12) return 16'($urandom_range(65535));
    v = level + $urandom_range(2 * spread) - spread;
    if (pick < 22) v = v + (($urandom_range(1)) ? 1 : -1) * $urandom_range(20000, 2000);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  task automatic run_phase(logic [11:0] wc, logic [15:0] thr, logic [15:0] gain, int count);
    int level, spread;
    write_settings(wc, thr, gain);
    level  = $urandom_range(65535);
    spread = 1 << $urandom_range(12);
    for (int i = 0; i < count; i++) begin
      // occasional jump of the baseline to a new level
      if ($urandom_range(199) == 0) level = $urandom_range(65535);
      send_sample(next_signal(level, spread));
    end
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_index    <= REG_WINDOW_COUNT;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    sample       <= '0;
    idle_cycles  = 0;
    samples_sent = 0;
    settings_used = 0;
    no_gaps      = 1'b0;
    hold_request = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, warm-up of 16, then extremes once armed
    for (int i = 0; i < 16; i++) send_sample((i % 2) ? 16'hFFFF : 16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h5555);
    send_sample(16'hAAAA);

    // write to the unused index must change nothing
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_UNUSED_INDEX;
    cfg_data  <= 16'hFFFF;
    @(posedge clk);
    cfg_write <= 1'b0;
    for (int i = 0; i < 4; i++) send_sample(16'h1234);

    // random phases over window, threshold and gain settings
    run_phase(12'd1, 16'd0, 16'd0, 120);
    run_phase(12'd0, 16'hFFFF, 16'hFFFF, 80);
    run_phase(12'd2, 16'd0, 16'd768, 150);
    no_gaps = 1'b1;
    run_phase(12'd4, 16'd100, 16'd256, 200);
    no_gaps = 1'b0;
    run_phase(12'd8, 16'd1000, 16'd512, 200);
    hold_request = 1'b1;
    run_phase(12'd16, 16'd0, 16'hFFFF, 200);
    run_phase(12'd3, 16'hFFFF, 16'd0, 100);
    run_phase(12'd32, 16'd50, 16'd128, 150);
    drain_results();
    run_phase(12'd5, 16'd0, 16'd0, 120);
    // largest window, clipped from the top of the register range
    run_phase(12'hFFF, 16'd0, 16'd384, 60);
    run_phase(12'd2048, 16'd200, 16'd640, 60);
    run_phase(12'd7, 16'($urandom_range(65535)), 16'($urandom_range(65535)), 150);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run: %0d samples under %0d settings, %0d results (%0d up, %0d down)",
             samples_sent, settings_used, results_seen, ups_seen, downs_seen);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
